>>> hw/rtl/qau_pkg.sv
package qau_pkg;

    localparam int unsigned WORD_W = 16;

    typedef enum logic [1:0] {
        OP_QMUL = 2'd0,
        OP_VMUL = 2'd1,
        OP_CONJ = 2'd2,
        OP_NORM = 2'd3
    } t_op;

    typedef struct packed {
        t_op               req_type;
        logic signed [WORD_W-1:0] a_x;
        logic signed [WORD_W-1:0] a_y;
        logic signed [WORD_W-1:0] a_z;
        logic signed [WORD_W-1:0] a_w;
        logic signed [WORD_W-1:0] b_x;
        logic signed [WORD_W-1:0] b_y;
        logic signed [WORD_W-1:0] b_z;
        logic signed [WORD_W-1:0] b_w;
    } t_req;

    typedef struct packed {
        logic signed [WORD_W-1:0] r_x;
        logic signed [WORD_W-1:0] r_y;
        logic signed [WORD_W-1:0] r_z;
        logic signed [WORD_W-1:0] r_w;
        logic                     zero_length;
        logic                     saturated;
    } t_rsp;

endpackage

>>> hw/rtl/qau_core.sv
// Per-component pipeline, all stages advance together and take one item per cycle while i_en is high:
//   products, sums / sum of squares, square-root load, RW square-root stages (one root bit
//   each), division load, QW restoring-division stages (one quotient bit each, four lanes in
//   parallel), then round/saturate into the output register.
module qau_core #(
    parameter int FRAC_BITS = 14,
    parameter int WORD_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [1:0]                     i_op,
    input  logic signed [4*WORD_BITS-1:0]  i_a,
    input  logic signed [4*WORD_BITS-1:0]  i_b,
    output logic                           o_valid,
    output logic [4*WORD_BITS-1:0]         o_r,
    output logic                           o_zero,
    output logic                           o_sat
);
    import qau_pkg::*;

    localparam int PW  = 2*WORD_BITS;          // one product
    localparam int SW  = PW + 3;               // sum of four products / squares
    localparam int RW  = SW/2 + 1;             // root width
    localparam int QR  = 2*RW;                 // radicand padded to whole bit pairs
    localparam int NW  = WORD_BITS + FRAC_BITS; // dividend magnitude
    localparam int QW  = NW + 1;               // quotient bits (room for rounding)
    localparam int DEPTH = RW + QW + 4;
    localparam logic signed [WORD_BITS-1:0] PMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] NMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic       valid;
        logic [1:0] op;
    } t_ctl;

    // ---------------- stage 1: products
    logic signed [PW-1:0] r_p [16];
    t_ctl                 r_c1;
    logic signed [WORD_BITS-1:0] r_a1 [4];

    logic signed [WORD_BITS-1:0] a [4];
    logic signed [WORD_BITS-1:0] b [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            a[k] = i_a[k*WORD_BITS +: WORD_BITS];
            b[k] = i_b[k*WORD_BITS +: WORD_BITS];
        end
        if (i_op == OP_VMUL) b[3] = '0;
        if (i_op == OP_NORM) begin
            for (int k = 0; k < 4; k++) b[k] = a[k];
        end
    end

    // index: component order x,y,z,w = 0..3; r_p[4*i+j] = a[i]*b[j]
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
        end else if (i_en) begin
            r_c1 <= '{valid: i_valid, op: i_op};
        end
        if (i_en) begin
            for (int i = 0; i < 4; i++) begin
                r_a1[i] <= a[i];
                for (int j = 0; j < 4; j++) r_p[4*i+j] <= a[i] * b[j];
            end
        end
    end

    // ---------------- stage 2: sums
    function automatic logic signed [SW-1:0] ext(input logic signed [PW-1:0] v);
        ext = SW'(v);
    endfunction

    logic signed [SW-1:0] r_s [4];
    logic [SW-1:0]        r_sq;
    t_ctl                 r_c2;
    logic signed [WORD_BITS-1:0] r_a2 [4];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2 <= '0;
        end else if (i_en) begin
            r_c2 <= r_c1;
        end
        if (i_en) begin
            r_a2 <= r_a1;
            // w
            r_s[3] <= ext(r_p[15]) - ext(r_p[0]) - ext(r_p[5]) - ext(r_p[10]);
            // x
            r_s[0] <= ext(r_p[12]) + ext(r_p[3]) + ext(r_p[6]) - ext(r_p[9]);
            // y
            r_s[1] <= ext(r_p[13]) - ext(r_p[2]) + ext(r_p[7]) + ext(r_p[8]);
            // z
            r_s[2] <= ext(r_p[14]) + ext(r_p[1]) - ext(r_p[4]) + ext(r_p[11]);
            r_sq   <= SW'(ext(r_p[0]) + ext(r_p[5]) + ext(r_p[10]) + ext(r_p[15]));
        end
    end

    // ---------------- square root and division pipeline
    typedef struct packed {
        t_ctl                 c;
        logic [SW-1:0]        rem;
        logic [QR-1:0]        rad;
        logic [RW-1:0]        root;
    } t_sq;

    t_sq r_sqs [RW+1];
    logic signed [SW-1:0]        r_sd [RW+1][4];
    logic signed [WORD_BITS-1:0] r_ad [RW+1][4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqs[0].c <= '0;
        end else if (i_en) begin
            r_sqs[0].c <= r_c2;
        end
        if (i_en) begin
            r_sqs[0].rem  <= '0;
            r_sqs[0].rad  <= QR'(r_sq);
            r_sqs[0].root <= '0;
            r_sd[0] <= r_s;
            r_ad[0] <= r_a2;
        end
    end

    // digit-by-digit square root, two radicand bits per stage
    for (genvar g = 0; g < RW; g++) begin : g_sqrt
        logic [SW+1:0] rem2, trial;
        always_comb begin
            rem2  = {r_sqs[g].rem, r_sqs[g].rad[QR-1 -: 2]};
            trial = {(SW+2-RW-2)'(0), r_sqs[g].root, 2'b01};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sqs[g+1].c <= '0;
            end else if (i_en) begin
                r_sqs[g+1].c <= r_sqs[g].c;
            end
            if (i_en) begin
                r_sqs[g+1].rad <= {r_sqs[g].rad[QR-3:0], 2'b00};
                if (rem2 >= trial) begin
                    r_sqs[g+1].rem  <= SW'(rem2 - trial);
                    r_sqs[g+1].root <= {r_sqs[g].root[RW-2:0], 1'b1};
                end else begin
                    r_sqs[g+1].rem  <= SW'(rem2);
                    r_sqs[g+1].root <= {r_sqs[g].root[RW-2:0], 1'b0};
                end
                r_sd[g+1] <= r_sd[g];
                r_ad[g+1] <= r_ad[g];
            end
        end
    end

    // division: q = (mag*2^F + L/2) / L, restoring, one bit per stage
    localparam int DW = QW + RW; // partial remainder width
    typedef struct packed {
        t_ctl                c;
        logic [RW-1:0]       len;
        logic                zero;
    } t_dc;
    t_dc                        r_dc [QW+1];
    logic [DW-1:0]              r_rem [QW+1][4];
    logic [QW-1:0]              r_q   [QW+1][4];
    logic [3:0]                 r_neg [QW+1];
    logic signed [SW-1:0]       r_dsd [QW+1][4];

    logic [RW-1:0] root_f;
    assign root_f = r_sqs[RW].root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc[0].c <= '0;
        end else if (i_en) begin
            r_dc[0].c <= r_sqs[RW].c;
        end
        if (i_en) begin
            r_dc[0].len  <= root_f;
            r_dc[0].zero <= (root_f == '0);
            r_dsd[0]     <= r_sd[RW];
            for (int k = 0; k < 4; k++) begin
                logic [WORD_BITS:0] mg;
                mg = r_ad[RW][k][WORD_BITS-1]
                    ? (WORD_BITS+1)'(-{r_ad[RW][k][WORD_BITS-1], r_ad[RW][k]})
                    : (WORD_BITS+1)'({1'b0, r_ad[RW][k]});
                r_neg[0][k] <= r_ad[RW][k][WORD_BITS-1];
                r_rem[0][k] <= DW'({mg, FRAC_BITS'(0)}) + DW'(root_f >> 1);
                r_q[0][k]   <= '0;
            end
        end
    end

    // dividend sits in r_rem; shift quotient bits out from the top
    for (genvar g = 0; g < QW; g++) begin : g_div
        localparam int SH = QW - 1 - g;
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dc[g+1].c <= '0;
            end else if (i_en) begin
                r_dc[g+1].c <= r_dc[g].c;
            end
            if (i_en) begin
                r_dc[g+1].len  <= r_dc[g].len;
                r_dc[g+1].zero <= r_dc[g].zero;
                r_neg[g+1]     <= r_neg[g];
                r_dsd[g+1]     <= r_dsd[g];
                for (int k = 0; k < 4; k++) begin
                    if (!r_dc[g].zero &&
                        (r_rem[g][k] >> SH) >= DW'(r_dc[g].len)) begin
                        r_rem[g+1][k] <= r_rem[g][k] - (DW'(r_dc[g].len) << SH);
                        r_q[g+1][k]   <= r_q[g][k] | (QW'(1) << SH);
                    end else begin
                        r_rem[g+1][k] <= r_rem[g][k];
                        r_q[g+1][k]   <= r_q[g][k];
                    end
                end
            end
        end
    end

    // ---------------- final: round/saturate and select
    function automatic logic signed [WORD_BITS-1:0] sat_s(input logic signed [SW-1:0] v,
                                                       output logic s);
        logic signed [SW-1:0] t;
        t = v >>> FRAC_BITS;
        s = 1'b0;
        if (t > SW'(PMAX)) begin
            s = 1'b1; sat_s = PMAX;
        end else if (t < SW'(NMIN)) begin
            s = 1'b1; sat_s = NMIN;
        end else begin
            sat_s = WORD_BITS'(t);
        end
    endfunction

    t_ctl cf;
    assign cf = r_dc[QW].c;
    logic [4*WORD_BITS-1:0] n_r;
    logic n_zero, n_sat;

    always_comb begin
        logic s;
        logic signed [SW-1:0] rs;
        logic signed [SW-1:0] half;
        logic [QW-1:0] q;
        half  = SW'(1) <<< (FRAC_BITS-1);
        n_r   = '0;
        n_zero = 1'b0;
        n_sat = 1'b0;
        s = 1'b0;
        rs = '0;
        q = '0;
        for (int k = 0; k < 4; k++) begin
            unique case (t_op'(cf.op))
                OP_QMUL, OP_VMUL: begin
                    rs = r_dsd[QW][k] + half;
                    n_r[k*WORD_BITS +: WORD_BITS] = sat_s(rs, s);
                    n_sat = n_sat | s;
                end
                OP_CONJ: begin
                    n_r[k*WORD_BITS +: WORD_BITS] = '0;
                end
                OP_NORM: begin
                    q = r_q[QW][k];
                    if (r_dc[QW].zero) begin
                        n_zero = 1'b1;
                    end else if (!r_neg[QW][k]) begin
                        if (q > QW'(PMAX)) begin
                            n_sat = 1'b1;
                            n_r[k*WORD_BITS +: WORD_BITS] = PMAX;
                        end else begin
                            n_r[k*WORD_BITS +: WORD_BITS] = WORD_BITS'(q);
                        end
                    end else begin
                        if (q > QW'({1'b0, PMAX}) + QW'(1)) begin
                            n_sat = 1'b1;
                            n_r[k*WORD_BITS +: WORD_BITS] = NMIN;
                        end else begin
                            n_r[k*WORD_BITS +: WORD_BITS] = WORD_BITS'(-q);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // conjugate works from a copy of A that travels beside the pipeline
    logic signed [WORD_BITS-1:0] r_ca [DEPTH][4];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ca[0] <= a;
            for (int d = 1; d < DEPTH; d++) r_ca[d] <= r_ca[d-1];
        end
    end

    logic [4*WORD_BITS-1:0] conj_r;
    logic conj_s;
    always_comb begin
        logic signed [WORD_BITS-1:0] v;
        conj_s = 1'b0;
        conj_r = '0;
        v = '0;
        for (int k = 0; k < 4; k++) begin
            v = r_ca[DEPTH-1][k];
            if (k == 3) begin
                conj_r[k*WORD_BITS +: WORD_BITS] = v;
            end else if (v == NMIN) begin
                conj_s = 1'b1;
                conj_r[k*WORD_BITS +: WORD_BITS] = PMAX;
            end else begin
                conj_r[k*WORD_BITS +: WORD_BITS] = -v;
            end
        end
    end

    logic r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= cf.valid;
        end
        if (i_en) begin
            if (t_op'(cf.op) == OP_CONJ) begin
                o_r   <= conj_r;
                o_sat <= conj_s;
                o_zero <= 1'b0;
            end else begin
                o_r   <= n_r;
                o_sat <= n_sat;
                o_zero <= n_zero;
            end
        end
    end
    assign o_valid = r_v;

`ifndef SYNTH
    a_zero_only_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero |-> o_r == '0 && !o_sat)
        else $error("zero flag with nonzero result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_en |=> $stable(o_valid))
        else $error("pipeline moved while held");
    a_vfollow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && !cf.valid |=> !o_valid)
        else $error("valid appeared without source");
`endif
endmodule

>>> hw/rtl/quaternion_arithmetic_unit.sv
// Quaternion ALU, signed fixed point (Q2.14 by default). Takes one request per cycle while
// o_stall is low and returns one result per request in order. Every opcode runs through the
// same stages: products, sums, a square-root load stage, WORD_W + 2 square-root stages (one
// root bit each), a division load stage, WORD_W + FRAC_BITS + 1 division stages (one quotient
// bit each) and the output register. A result held by i_stall freezes the whole pipeline and
// raises o_stall until it is taken; without output stalls a new request can enter every cycle.
module quaternion_arithmetic_unit #(
    parameter int FRAC_BITS = 14
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  qau_pkg::t_req   i_req,
    output logic            o_valid,
    input  logic            i_stall,
    output qau_pkg::t_rsp   o_rsp
);
    import qau_pkg::*;

    logic en, cv, cz, cs;
    logic [4*WORD_W-1:0] cr;

    // advance whenever the output slot is free or being taken
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    qau_core #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_W)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_op    (i_req.req_type),
        .i_a     ({i_req.a_w, i_req.a_z, i_req.a_y, i_req.a_x}),
        .i_b     ({i_req.b_w, i_req.b_z, i_req.b_y, i_req.b_x}),
        .o_valid (cv),
        .o_r     (cr),
        .o_zero  (cz),
        .o_sat   (cs)
    );

    assign o_valid           = cv;
    assign o_rsp.r_x         = cr[0*WORD_W +: WORD_W];
    assign o_rsp.r_y         = cr[1*WORD_W +: WORD_W];
    assign o_rsp.r_z         = cr[2*WORD_W +: WORD_W];
    assign o_rsp.r_w         = cr[3*WORD_W +: WORD_W];
    assign o_rsp.zero_length = cz;
    assign o_rsp.saturated   = cs;
endmodule
